// ===== src/pct_pkg.sv =====
// peer card table: shared item, result and token types plus action and status codes
// no dependencies
package pct_pkg;

  localparam logic [1:0] ACT_OFFER = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [2:0] ST_UPDATED   = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_SELF      = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_SHORT     = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;
  localparam logic [2:0] ST_READ      = 3'd6;
  localparam logic [2:0] ST_BAD_INDEX = 3'd7;

  localparam logic REG_OWN_HIGH = 1'b0;
  localparam logic REG_OWN_LOW  = 1'b1;

  localparam logic [5:0] MIN_CARD_LEN = 6'd28;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] card_handle_high;
    logic [63:0] card_handle_low;
    logic [63:0] card_org;
    logic [31:0] card_fingerprint;
    logic [5:0]  packet_length;
    logic [30:0] now_ms;
    logic [2:0]  entry_index;
  } pct_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [3:0]  entry_count;
    logic [63:0] out_handle_high;
    logic [63:0] out_handle_low;
    logic [63:0] out_org;
    logic [31:0] out_fingerprint;
    logic [30:0] out_seen_ms;
  } pct_out_t;

  // one operation travelling down the row of entries
  typedef struct packed {
    logic        valid;
    logic [1:0]  action;
    logic        short_card;
    logic        self_card;
    logic [63:0] handle_high;
    logic [63:0] handle_low;
    logic [63:0] org;
    logic [31:0] fingerprint;
    logic [30:0] now_ms;
    logic [2:0]  entry_index;
    logic        found;
    logic        inserted;
    logic        read_hit;
    logic [2:0]  slot;
    logic [63:0] rd_handle_high;
    logic [63:0] rd_handle_low;
    logic [63:0] rd_org;
    logic [31:0] rd_fingerprint;
    logic [30:0] rd_seen_ms;
  } pct_token_t;

endpackage

// ===== src/pct_front.sv =====
// peer card table: front stage, trims handles and org at their first zero byte
// and flags short and self cards; depends on pct_pkg
module pct_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  pct_pkg::pct_in_t   item,
  input  logic [63:0]        own_handle_high,
  input  logic [63:0]        own_handle_low,
  output pct_pkg::pct_token_t tok
);
  import pct_pkg::*;

  function automatic logic [127:0] trim16(input logic [127:0] w);
    logic [127:0] r;
    logic ended;
    r = '0;
    ended = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (!ended) begin
        r[127 - 8 * i -: 8] = w[127 - 8 * i -: 8];
        if (w[127 - 8 * i -: 8] == 8'd0) ended = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] trim8(input logic [63:0] w);
    logic [63:0] r;
    logic ended;
    r = '0;
    ended = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!ended) begin
        r[63 - 8 * i -: 8] = w[63 - 8 * i -: 8];
        if (w[63 - 8 * i -: 8] == 8'd0) ended = 1'b1;
      end
    end
    return r;
  endfunction

  logic [127:0] card_h;
  logic [127:0] own_h;

  assign card_h = trim16({item.card_handle_high, item.card_handle_low});
  assign own_h  = trim16({own_handle_high, own_handle_low});

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else begin
      tok.valid <= accept;
    end
    if (accept) begin
      tok.action         <= item.action;
      tok.short_card     <= item.packet_length < MIN_CARD_LEN;
      tok.self_card      <= card_h == own_h;
      tok.handle_high    <= card_h[127:64];
      tok.handle_low     <= card_h[63:0];
      tok.org            <= trim8(item.card_org);
      tok.fingerprint    <= item.card_fingerprint;
      tok.now_ms         <= item.now_ms;
      tok.entry_index    <= item.entry_index;
      tok.found          <= 1'b0;
      tok.inserted       <= 1'b0;
      tok.read_hit       <= 1'b0;
      tok.slot           <= '0;
      tok.rd_handle_high <= '0;
      tok.rd_handle_low  <= '0;
      tok.rd_org         <= '0;
      tok.rd_fingerprint <= '0;
      tok.rd_seen_ms     <= '0;
    end
  end

endmodule

// ===== src/pct_cell.sv =====
// peer card table: one table entry; matches, inserts or reads as the token passes
// depends on pct_pkg
module pct_cell #(
  parameter int TABLE_DEPTH = 8,
  parameter int INDEX       = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]   count,
  input  pct_pkg::pct_token_t                tok_in,
  output pct_pkg::pct_token_t                tok_out
);
  import pct_pkg::*;

  logic [63:0] handle_high;
  logic [63:0] handle_low;
  logic [63:0] org;
  logic [31:0] fingerprint;
  logic [30:0] seen_ms;

  logic in_use;
  logic offer;
  logic match;
  logic ins;
  logic rd;

  assign in_use = 32'(count) > INDEX;
  assign offer  = tok_in.valid && tok_in.action == ACT_OFFER &&
                  !tok_in.short_card && !tok_in.self_card && !tok_in.found;
  assign match  = offer && in_use && handle_high == tok_in.handle_high &&
                  handle_low == tok_in.handle_low;
  // every entry in use has been checked by the time the token reaches the first free one
  assign ins    = offer && 32'(count) == INDEX;
  assign rd     = tok_in.valid && tok_in.action == ACT_READ && in_use &&
                  32'(tok_in.entry_index) == INDEX;

  always_ff @(posedge clk) begin
    if (match || ins) begin
      org         <= tok_in.org;
      fingerprint <= tok_in.fingerprint;
      seen_ms     <= tok_in.now_ms;
    end
    if (ins) begin
      handle_high <= tok_in.handle_high;
      handle_low  <= tok_in.handle_low;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.action      <= tok_in.action;
    tok_out.short_card  <= tok_in.short_card;
    tok_out.self_card   <= tok_in.self_card;
    tok_out.handle_high <= tok_in.handle_high;
    tok_out.handle_low  <= tok_in.handle_low;
    tok_out.org         <= tok_in.org;
    tok_out.fingerprint <= tok_in.fingerprint;
    tok_out.now_ms      <= tok_in.now_ms;
    tok_out.entry_index <= tok_in.entry_index;
    tok_out.found       <= tok_in.found || match;
    tok_out.inserted    <= tok_in.inserted || ins;
    tok_out.read_hit    <= tok_in.read_hit || rd;
    tok_out.slot        <= (match || ins || rd) ? 3'(INDEX) : tok_in.slot;
    if (rd) begin
      tok_out.rd_handle_high <= handle_high;
      tok_out.rd_handle_low  <= handle_low;
      tok_out.rd_org         <= org;
      tok_out.rd_fingerprint <= fingerprint;
      tok_out.rd_seen_ms     <= seen_ms;
    end else begin
      tok_out.rd_handle_high <= tok_in.rd_handle_high;
      tok_out.rd_handle_low  <= tok_in.rd_handle_low;
      tok_out.rd_org         <= tok_in.rd_org;
      tok_out.rd_fingerprint <= tok_in.rd_fingerprint;
      tok_out.rd_seen_ms     <= tok_in.rd_seen_ms;
    end
  end

endmodule

// ===== src/peer_card_table.sv =====
// peer card table: top level with front stage, row of entry cells and result register
// depends on pct_pkg, pct_front, pct_cell
//
// Usage:
//   in channel (in_valid / in_stall / in_data) carries one action per transaction:
//   offer a card, clear the table or read one entry. out channel (out_valid /
//   out_stall / out_data) returns exactly one result per input transaction.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the own
//   handle words; cfg_ready is always high; the user must write only while idle (not enforced).
// Timing:
//   an accepted transaction is registered in the front stage, then walks the row
//   of TABLE_DEPTH entry cells at one cell per cycle, lands in a completion
//   register and moves to the output register. One transaction is in flight
//   at a time; in_stall falls again once the result sits in the output
//   register, so no new transaction is taken before the last one is through.
// Reset:
//   rst empties the table (entry count zero), clears the own handle and drops
//   any transaction in flight. Entry contents are not cleared.
// Stall:
//   while out_stall is high the result holds; a finished follow-on result waits
//   in the completion register and in_stall stays high until it moves on.
module peer_card_table #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pct_pkg::pct_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pct_pkg::pct_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [63:0]       cfg_data
);
  import pct_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [63:0]   own_handle_high;
  logic [63:0]   own_handle_low;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          busy;
  logic          accept;
  logic          done_valid;
  pct_out_t      done;
  pct_out_t      done_next;
  logic          move_out;

  pct_token_t    tok [TABLE_DEPTH+1];
  pct_token_t    last;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign accept    = in_valid && !busy;
  assign move_out  = done_valid && (!out_valid || !out_stall);
  assign last      = tok[TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      own_handle_high <= '0;
      own_handle_low  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OWN_HIGH: own_handle_high <= cfg_data;
        REG_OWN_LOW:  own_handle_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  pct_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .item            (in_data),
    .own_handle_high (own_handle_high),
    .own_handle_low  (own_handle_low),
    .tok             (tok[0])
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    pct_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .INDEX       (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .count   (count),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  always_comb begin
    count_next = count;
    done_next  = '0;
    case (last.action)
      ACT_OFFER: begin
        if (last.short_card) begin
          done_next.status = ST_SHORT;
        end else if (last.self_card) begin
          done_next.status = ST_SELF;
        end else if (last.found) begin
          done_next.status = ST_UPDATED;
          done_next.slot   = last.slot;
        end else if (last.inserted) begin
          done_next.status = ST_INSERTED;
          done_next.slot   = last.slot;
          count_next       = count + 1'b1;
        end else begin
          done_next.status = ST_FULL;
        end
      end
      ACT_CLEAR: begin
        done_next.status = ST_CLEARED;
        count_next       = '0;
      end
      ACT_READ: begin
        if (last.read_hit) begin
          done_next.status          = ST_READ;
          done_next.slot            = last.slot;
          done_next.out_handle_high = last.rd_handle_high;
          done_next.out_handle_low  = last.rd_handle_low;
          done_next.out_org         = last.rd_org;
          done_next.out_fingerprint = last.rd_fingerprint;
          done_next.out_seen_ms     = last.rd_seen_ms;
        end else begin
          done_next.status = ST_BAD_INDEX;
        end
      end
      default: begin
        done_next.status = ST_BAD_INDEX;
      end
    endcase
    done_next.entry_count = 4'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      busy       <= 1'b0;
      done_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) busy <= 1'b1;
      else if (move_out) busy <= 1'b0;
      if (last.valid) begin
        count      <= count_next;
        done_valid <= 1'b1;
      end else if (move_out) begin
        done_valid <= 1'b0;
      end
      if (move_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    if (last.valid) done <= done_next;
    if (move_out) out_data <= done;
  end

endmodule

// ===== tb/peer_card_table_test.sv =====
`timescale 1ns / 1ps
// peer card table testbench: directed and random card traffic with own-handle changes,
// every result checked against a table predictor; depends on pct_pkg and peer_card_table
module peer_card_table_test;
  import pct_pkg::*;

  localparam int TABLE_DEPTH = 8;
  localparam int IDLE_LIMIT = 3000;
  localparam int POOL_SIZE = 12;
  localparam int HOLD_CYCLES = 200;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef enum int {OWN_FROM_POOL, OWN_RANDOM, OWN_ZERO, OWN_ONES} own_choice_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pct_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pct_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_OWN_HIGH;
  logic [63:0] cfg_data = '0;

  peer_card_table #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predicted table contents
  logic [127:0] own_handle = '0;
  logic [127:0] entry_handle [TABLE_DEPTH];
  logic [63:0]  entry_org [TABLE_DEPTH];
  logic [31:0]  entry_fingerprint [TABLE_DEPTH];
  logic [30:0]  entry_seen [TABLE_DEPTH];
  int           table_count = 0;

  pct_out_t     pending_results [$];
  logic [127:0] handle_pool [POOL_SIZE];
  int           error_count = 0;
  int           sender_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_left = 0;
  int           idle_cycles = 0;

  // bytes after the first zero byte become zero, or random garbage when scramble is set
  function automatic logic [127:0] zero_tail(logic [127:0] v, logic scramble);
    logic [127:0] r;
    logic         ended;
    r = v;
    ended = 1'b0;
    for (int k = 0; k < 16; k++) begin
      if (ended) begin
        r[127 - 8*k -: 8] = scramble ? 8'($urandom_range(255)) : 8'h00;
      end else if (v[127 - 8*k -: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return r;
  endfunction

  // updates the predicted table and queues the answer for one accepted transaction
  task automatic apply_card_action(pct_in_t it);
    pct_out_t     r;
    logic [127:0] h;
    logic [127:0] og;
    logic         found;
    r = '0;
    r.status = ST_BAD_INDEX;
    case (it.action)
      ACT_OFFER: begin
        if (it.packet_length < MIN_CARD_LEN) begin
          r.status = ST_SHORT;
        end else begin
          h = zero_tail({it.card_handle_high, it.card_handle_low}, 1'b0);
          og = zero_tail({it.card_org, 64'd0}, 1'b0);
          if (h == zero_tail(own_handle, 1'b0)) begin
            r.status = ST_SELF;
          end else begin
            found = 1'b0;
            for (int i = 0; i < table_count; i++) begin
              if (!found && entry_handle[i] == h) begin
                found = 1'b1;
                entry_org[i] = og[127:64];
                entry_fingerprint[i] = it.card_fingerprint;
                entry_seen[i] = it.now_ms;
                r.status = ST_UPDATED;
                r.slot = 3'(i);
              end
            end
            if (!found && table_count < TABLE_DEPTH) begin
              entry_handle[table_count] = h;
              entry_org[table_count] = og[127:64];
              entry_fingerprint[table_count] = it.card_fingerprint;
              entry_seen[table_count] = it.now_ms;
              r.status = ST_INSERTED;
              r.slot = 3'(table_count);
              table_count++;
            end else if (!found) begin
              r.status = ST_FULL;
            end
          end
        end
      end
      ACT_CLEAR: begin
        table_count = 0;
        r.status = ST_CLEARED;
      end
      ACT_READ: begin
        if (it.entry_index < table_count) begin
          r.status = ST_READ;
          r.slot = it.entry_index;
          {r.out_handle_high, r.out_handle_low} = entry_handle[it.entry_index];
          r.out_org = entry_org[it.entry_index];
          r.out_fingerprint = entry_fingerprint[it.entry_index];
          r.out_seen_ms = entry_seen[it.entry_index];
        end
      end
      default: r.status = ST_BAD_INDEX;
    endcase
    r.entry_count = 4'(table_count);
    pending_results.push_back(r);
  endtask

  task automatic send_action(pct_in_t it);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_card_action(it);
  endtask

  task automatic drain_results;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_own_handle(logic [127:0] v);
    drain_results;
    for (int r = 0; r < 2; r++) begin
      @(negedge clk);
      cfg_valid = 1'b1;
      cfg_index = (r == 0) ? REG_OWN_HIGH : REG_OWN_LOW;
      cfg_data = (r == 0) ? v[127:64] : v[63:0];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    own_handle = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic make_random_item(output pct_in_t it);
    int           pick;
    int           pos;
    logic [127:0] h;
    pick = $urandom_range(99);
    h = zero_tail(handle_pool[$urandom_range(POOL_SIZE - 1)], 1'b1);
    if ($urandom_range(99) < 7) begin
      h = zero_tail(own_handle, 1'b1);
    end else if ($urandom_range(99) < 8) begin
      h = {$urandom, $urandom, $urandom, $urandom};
    end
    it.action = ACT_OFFER;
    {it.card_handle_high, it.card_handle_low} = h;
    it.card_org = {$urandom, $urandom};
    if ($urandom_range(2) == 0) begin
      pos = $urandom_range(7);
      it.card_org[63 - 8*pos -: 8] = 8'h00;
    end
    it.card_fingerprint = $urandom;
    it.now_ms = 31'($urandom);
    it.entry_index = 3'($urandom_range(7));
    it.packet_length = 6'($urandom_range(63, 28));
    if (pick >= 96) begin
      it.action = ACT_UNUSED;
    end else if (pick >= 69) begin
      it.action = ACT_READ;
    end else if (pick >= 65) begin
      it.action = ACT_CLEAR;
    end else if (pick >= 55) begin
      it.packet_length = 6'($urandom_range(27));
    end
  endtask

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    pct_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none got status %0d",
                 $time, out_data.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", 64'(want.status), 64'(out_data.status));
        compare_field("slot", 64'(want.slot), 64'(out_data.slot));
        compare_field("entry_count", 64'(want.entry_count), 64'(out_data.entry_count));
        compare_field("out_handle_high", want.out_handle_high, out_data.out_handle_high);
        compare_field("out_handle_low", want.out_handle_low, out_data.out_handle_low);
        compare_field("out_org", want.out_org, out_data.out_org);
        compare_field("out_fingerprint", 64'(want.out_fingerprint),
                      64'(out_data.out_fingerprint));
        compare_field("out_seen_ms", 64'(want.out_seen_ms), 64'(out_data.out_seen_ms));
      end
    end
  end

  // receiver: long hold-off when requested, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[peer_card_table] ERROR");
      $finish;
    end
  end

  task automatic test_empty_table;
    pct_in_t it;
    it = '0;
    it.action = ACT_READ;
    send_action(it);
    it = '1;
    it.action = ACT_UNUSED;
    send_action(it);
    it.action = ACT_OFFER;
    it.packet_length = 6'd0;
    send_action(it);
    it.packet_length = 6'd27;
    send_action(it);
    // own handle is zero after reset, so a leading zero byte makes the card ours
    it.card_handle_high = 64'h00FF_FFFF_FFFF_FFFF;
    it.packet_length = MIN_CARD_LEN;
    send_action(it);
    it.card_handle_high = '1;
    send_action(it);
    it.card_handle_high = 64'h1022_3300_9A5C_71E4;
    it.card_handle_low = 64'h0123_4567_89AB_CDEF;
    it.card_org = 64'h4142_4300_7788_99AA;
    it.card_fingerprint = 32'h0;
    it.now_ms = 31'd0;
    it.packet_length = 6'd63;
    send_action(it);
    // same handle up to its terminator, different garbage behind it
    it.card_handle_high = 64'h1022_3300_5555_AAAA;
    it.card_handle_low = 64'hF0E1_D2C3_B4A5_9687;
    it.card_org = 64'h6162_6364_6566_6768;
    it.card_fingerprint = 32'h1234_5678;
    it.now_ms = 31'd12345;
    it.packet_length = 6'd32;
    send_action(it);
    it.action = ACT_READ;
    it.entry_index = 3'd1;
    send_action(it);
    it.entry_index = 3'd0;
    send_action(it);
  endtask

  task automatic test_own_handle;
    pct_in_t it;
    write_own_handle('1);
    it = '1;
    it.action = ACT_OFFER;
    it.packet_length = 6'd40;
    send_action(it);
    write_own_handle({64'h5A6B_7C00_1234_5678, 64'h9ABC_DEF0_1357_9BDF});
    it.card_handle_high = 64'h5A6B_7C00_FFFF_0000;
    it.card_handle_low = 64'h0;
    send_action(it);
  endtask

  task automatic test_full_table;
    pct_in_t it;
    it = '0;
    it.action = ACT_OFFER;
    it.packet_length = MIN_CARD_LEN;
    for (int k = 2; k <= TABLE_DEPTH; k++) begin
      it.card_handle_high = {8'(8'h20 + k), 24'($urandom), $urandom};
      it.card_handle_low = {$urandom, $urandom};
      it.card_org = {$urandom, $urandom};
      it.card_fingerprint = $urandom;
      it.now_ms = 31'($urandom);
      send_action(it);
    end
    it.action = ACT_READ;
    it.entry_index = 3'd7;
    send_action(it);
    it.action = ACT_CLEAR;
    send_action(it);
    it.action = ACT_READ;
    it.entry_index = 3'd0;
    send_action(it);
  endtask

  task automatic test_random_traffic(int n_items, int send_idle, int recv_idle,
                                     own_choice_t own_sel);
    pct_in_t      it;
    logic [127:0] v;
    int           pos;
    for (int p = 0; p < POOL_SIZE; p++) begin
      handle_pool[p] = {$urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(9) < 4) begin
        pos = $urandom_range(15, 1);
        handle_pool[p][127 - 8*pos -: 8] = 8'h00;
      end
    end
    case (own_sel)
      OWN_FROM_POOL: v = zero_tail(handle_pool[0], 1'b1);
      OWN_RANDOM:    v = {$urandom, $urandom, $urandom, $urandom};
      OWN_ZERO:      v = '0;
      default:       v = '1;
    endcase
    write_own_handle(v);
    sender_idle_pct = send_idle;
    recv_stall_pct = recv_idle;
    repeat (n_items) begin
      make_random_item(it);
      send_action(it);
    end
    drain_results;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure;
    pct_in_t it;
    @(negedge clk);
    hold_left = HOLD_CYCLES;
    repeat (6) begin
      make_random_item(it);
      send_action(it);
    end
    // sender waits for every answer before each further transaction
    drain_results;
    repeat (20) begin
      make_random_item(it);
      send_action(it);
      drain_results;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_table;
    test_own_handle;
    test_full_table;
    test_random_traffic(350, 0, 0, OWN_FROM_POOL);
    test_random_traffic(350, 74, 0, OWN_RANDOM);
    test_random_traffic(350, 0, 74, OWN_ZERO);
    test_random_traffic(350, 8, 8, OWN_ONES);
    test_backpressure;
    drain_results;
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("[peer_card_table] OK");
    end else begin
      $display("[peer_card_table] ERROR");
    end
    $finish;
  end

endmodule
